>>> rtl/erwl_pkg.sv
// shared constants, codes and types of the eeprom record wear leveler
package erwl_pkg;

	// store geometry (store size is a power of two, addresses wrap modulo it)
	localparam int STORE_BYTES  = 1024;
	localparam int HEADER_BYTES = 1;
	localparam int ADDR_W       = $clog2(STORE_BYTES);

	// field widths
	localparam int CMD_W   = 2;
	localparam int SIZE_W  = 2;
	localparam int OFF_W   = 10;
	localparam int VAL_W   = 32;
	localparam int SLOT_W  = 10;
	localparam int SADDR_W = 11;
	localparam int BASE_W  = 10;
	localparam int END_W   = 11;
	localparam int LEN_W   = 10;
	localparam int MARK_W  = 8;
	localparam int BYTE_W  = 8;

	// internal widths
	localparam int SSIZE_W = LEN_W + 1;
	localparam int START_W = SLOT_W + SSIZE_W + 1;
	localparam int IDX_W   = SLOT_W + 1;
	localparam int NB_W    = 3;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_BASE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REC_LEN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VALID     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INVALID   = 3'd5;

	// register reset values
	localparam logic [BASE_W-1:0] RST_BASE      = 10'd0;
	localparam logic [END_W-1:0]  RST_END_LIMIT = 11'd1024;
	localparam logic [LEN_W-1:0]  RST_REC_LEN   = 10'd16;
	localparam logic              RST_ROTATE    = 1'b1;
	localparam logic [MARK_W-1:0] RST_VALID     = 8'h00;
	localparam logic [MARK_W-1:0] RST_INVALID   = 8'hFF;

	// erased store byte
	localparam logic [BYTE_W-1:0] ERASED = 8'hFF;

	// commands
	localparam logic [CMD_W-1:0] CMD_READ    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RECOVER = 2'd2;

	// field sizes
	localparam logic [SIZE_W-1:0] SIZE_ONE  = 2'd0;
	localparam logic [SIZE_W-1:0] SIZE_TWO  = 2'd1;
	localparam logic [SIZE_W-1:0] SIZE_FOUR = 2'd2;

	typedef struct packed {
		logic [BASE_W-1:0] base_address;
		logic [END_W-1:0]  end_limit;
		logic [LEN_W-1:0]  record_length;
		logic              rotate_mode;
		logic [MARK_W-1:0] valid_mark;
		logic [MARK_W-1:0] invalid_mark;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [SIZE_W-1:0] field_size;
		logic [OFF_W-1:0]  record_offset;
		logic [VAL_W-1:0]  write_value;
	} item_t;

	typedef struct packed {
		logic [VAL_W-1:0]   read_value;
		logic [SLOT_W-1:0]  slot_number;
		logic [SADDR_W-1:0] slot_address;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] wdata;
	} mem_req_t;

endpackage

>>> rtl/erwl_if.sv
// item, result and configuration channel interfaces
interface erwl_in_if import erwl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [SIZE_W-1:0] field_size;
	logic [OFF_W-1:0]  record_offset;
	logic [VAL_W-1:0]  write_value;

	modport source(output valid, command, field_size, record_offset, write_value,
		input ready);
	modport sink(input valid, command, field_size, record_offset, write_value,
		output ready);
endinterface

interface erwl_out_if import erwl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VAL_W-1:0]   read_value;
	logic [SLOT_W-1:0]  slot_number;
	logic [SADDR_W-1:0] slot_address;

	modport source(output valid, read_value, slot_number, slot_address, input ready);
	modport sink(input valid, read_value, slot_number, slot_address, output ready);
endinterface

interface erwl_cfg_if import erwl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/erwl_ram.sv
// generic single port ram with registered read
module erwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and read data register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/erwl_cfg.sv
// configuration register file
module erwl_cfg import erwl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	erwl_cfg_if.sink wr,
	output cfg_t   regs
);

	assign wr.ready = 1'b1;

	// register writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.base_address  <= RST_BASE;
			regs.end_limit     <= RST_END_LIMIT;
			regs.record_length <= RST_REC_LEN;
			regs.rotate_mode   <= RST_ROTATE;
			regs.valid_mark    <= RST_VALID;
			regs.invalid_mark  <= RST_INVALID;
		end else if (wr.valid) begin
			unique case (wr.index)
				REG_BASE:      regs.base_address  <= wr.data[BASE_W-1:0];
				REG_END_LIMIT: regs.end_limit     <= wr.data[END_W-1:0];
				REG_REC_LEN:   regs.record_length <= wr.data[LEN_W-1:0];
				REG_ROTATE:    regs.rotate_mode   <= wr.data[0];
				REG_VALID:     regs.valid_mark    <= wr.data[MARK_W-1:0];
				REG_INVALID:   regs.invalid_mark  <= wr.data[MARK_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/erwl_seq.sv
// command sequencer: read, copy and header updates through the store port
module erwl_seq import erwl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  item_t             in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output res_t              out_res,
	output mem_req_t          mem_req,
	input  logic [BYTE_W-1:0] mem_rdata
);

	typedef enum logic [15:0] {
		S_CLEAR    = 16'h0001,
		S_IDLE     = 16'h0002,
		S_MUL      = 16'h0004,
		S_SETUP    = 16'h0008,
		S_RD_ISSUE = 16'h0010,
		S_RD_WAIT  = 16'h0020,
		S_NEXT     = 16'h0040,
		S_CP_STEP  = 16'h0080,
		S_CP_WR    = 16'h0100,
		S_HDR_NEW  = 16'h0200,
		S_HDR_OLD  = 16'h0400,
		S_SM_HDR   = 16'h0800,
		S_SM_CHK   = 16'h1000,
		S_SM_FIELD = 16'h2000,
		S_SC_CHK   = 16'h4000,
		S_SC_CMP   = 16'h8000
	} state_t;

	// result hand-off shares the idle code space via a separate flag
	state_t             state_q;
	logic               done_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [SLOT_W-1:0]  live_q;
	logic [IDX_W-1:0]   idx_q;
	logic               out_valid_q;

	item_t              item_q;
	logic [NB_W-1:0]    nbytes_q;
	logic [START_W-1:0] prod_q;
	logic [START_W-1:0] cur_start_q;
	logic [START_W-1:0] ns_start_q;
	logic [SLOT_W-1:0]  nxt_q;
	logic [START_W-1:0] scan_start_q;
	logic [VAL_W-1:0]   rd_acc_q;
	res_t               res_q;

	logic [SSIZE_W-1:0] slot_sz;
	logic [START_W-1:0] setup_start;
	logic [START_W-1:0] cand;
	logic               wrap;
	logic [OFF_W-1:0]   cp_i;
	logic [OFF_W-1:0]   cp_d;
	logic               cp_in_field;
	logic               cp_last;
	logic               nb_last;
	logic [IDX_W-1:0]   sm_pos;
	logic               sm_in_rec;
	logic               scan_end;
	logic               hit;
	logic               out_free;
	logic [ADDR_W-1:0]  os_addr;
	logic [ADDR_W-1:0]  ns_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  sm_addr;
	logic [BYTE_W-1:0]  cp_byte;
	logic [BYTE_W-1:0]  sm_byte;

	// bytes covered by a field size code
	function automatic logic [NB_W-1:0] size_bytes(input logic [SIZE_W-1:0] sz);
		logic [NB_W-1:0] n;
		case (sz)
			SIZE_ONE:  n = 3'd1;
			SIZE_TWO:  n = 3'd2;
			SIZE_FOUR: n = 3'd4;
			default:   n = 3'd0;
		endcase
		return n;
	endfunction

	// slot geometry
	assign slot_sz     = SSIZE_W'(cfg.record_length) + SSIZE_W'(HEADER_BYTES);
	assign setup_start = cfg.rotate_mode ? START_W'(cfg.base_address) + prod_q
		: START_W'(cfg.base_address);
	assign cand        = cur_start_q + START_W'(slot_sz);
	assign wrap        = cand > START_W'(cfg.end_limit);

	// copy loop position and field overlap
	assign cp_i        = idx_q[OFF_W-1:0];
	assign cp_d        = cp_i - item_q.record_offset;
	assign cp_in_field = (cp_i >= item_q.record_offset) && (cp_d < OFF_W'(nbytes_q));
	assign cp_last     = (idx_q + IDX_W'(1)) == IDX_W'(cfg.record_length);
	assign cp_byte     = item_q.write_value[{cp_d[1:0], 3'b000} +: BYTE_W];
	assign os_addr     = cur_start_q[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES) + ADDR_W'(cp_i);
	assign ns_addr     = ns_start_q[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES) + ADDR_W'(cp_i);

	// field byte loops for reads and in-place writes
	assign nb_last   = (idx_q + IDX_W'(1)) == IDX_W'(nbytes_q);
	assign rd_addr   = cur_start_q[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES)
		+ ADDR_W'(item_q.record_offset) + ADDR_W'(idx_q[1:0]);
	assign sm_pos    = IDX_W'(item_q.record_offset) + idx_q;
	assign sm_in_rec = sm_pos < IDX_W'(cfg.record_length);
	assign sm_addr   = ADDR_W'(cfg.base_address) + ADDR_W'(HEADER_BYTES)
		+ ADDR_W'(item_q.record_offset) + ADDR_W'(idx_q[1:0]);
	assign sm_byte   = item_q.write_value[{idx_q[1:0], 3'b000} +: BYTE_W];

	// header scan
	assign scan_end = idx_q[IDX_W-1] || (scan_start_q >= START_W'(cfg.end_limit));
	assign hit      = mem_rdata == cfg.valid_mark;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && !done_q;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			done_q      <= 1'b0;
			clr_q       <= '0;
			live_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (done_q) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							done_q      <= 1'b0;
						end
					end else if (in_valid) begin
						idx_q   <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_SETUP;
				S_SETUP: begin
					case (item_q.command)
						CMD_READ: begin
							if (nbytes_q == '0) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_RD_ISSUE;
							end
						end
						CMD_WRITE: begin
							if (nbytes_q == '0) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else if (cfg.rotate_mode) begin
								state_q <= S_NEXT;
							end else begin
								state_q <= S_SM_HDR;
							end
						end
						CMD_RECOVER: state_q <= S_SC_CHK;
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_RD_ISSUE: state_q <= S_RD_WAIT;
				S_RD_WAIT: begin
					if (nb_last) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_RD_ISSUE;
					end
				end
				S_NEXT: begin
					state_q <= (cfg.record_length == '0) ? S_HDR_NEW : S_CP_STEP;
				end
				S_CP_STEP, S_CP_WR: begin
					if (state_q == S_CP_STEP && !cp_in_field) begin
						state_q <= S_CP_WR;
					end else if (cp_last) begin
						state_q <= S_HDR_NEW;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_CP_STEP;
					end
				end
				S_HDR_NEW: state_q <= S_HDR_OLD;
				S_HDR_OLD: begin
					live_q  <= nxt_q;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SM_HDR: state_q <= S_SM_CHK;
				S_SM_CHK: state_q <= S_SM_FIELD;
				S_SM_FIELD: begin
					if (nb_last) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_SC_CHK: begin
					if (scan_end) begin
						live_q  <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SC_CMP;
					end
				end
				S_SC_CMP: begin
					if (hit) begin
						live_q  <= idx_q[SLOT_W-1:0];
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_SC_CHK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and address datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (done_q) begin
					if (out_free) begin
						res_q.read_value   <= rd_acc_q;
						res_q.slot_number  <= cfg.rotate_mode ? live_q : '0;
						res_q.slot_address <= cfg.rotate_mode ? cur_start_q[SADDR_W-1:0]
							: SADDR_W'(cfg.base_address);
					end
				end else if (in_valid) begin
					item_q   <= in_item;
					nbytes_q <= size_bytes(in_item.field_size);
					rd_acc_q <= '0;
				end
			end
			S_MUL: prod_q <= START_W'(live_q) * START_W'(slot_sz);
			S_SETUP: begin
				cur_start_q  <= setup_start;
				scan_start_q <= START_W'(cfg.base_address);
			end
			S_RD_WAIT: rd_acc_q[{idx_q[1:0], 3'b000} +: BYTE_W] <= mem_rdata;
			S_NEXT: begin
				nxt_q      <= wrap ? '0 : live_q + SLOT_W'(1);
				ns_start_q <= (wrap || (&live_q)) ? START_W'(cfg.base_address) : cand;
			end
			S_HDR_OLD: cur_start_q <= ns_start_q;
			S_SC_CHK: begin
				if (scan_end) begin
					cur_start_q <= START_W'(cfg.base_address);
				end
			end
			S_SC_CMP: begin
				if (hit) begin
					cur_start_q <= scan_start_q;
				end else begin
					scan_start_q <= scan_start_q + START_W'(slot_sz);
				end
			end
			default: begin
			end
		endcase
	end

	// store port request
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.addr  = cur_start_q[ADDR_W-1:0];
		mem_req.wdata = ERASED;
		unique case (state_q)
			S_CLEAR: begin
				mem_req.we   = 1'b1;
				mem_req.addr = clr_q;
			end
			S_RD_ISSUE: mem_req.addr = rd_addr;
			S_CP_STEP: begin
				if (cp_in_field) begin
					mem_req.we    = 1'b1;
					mem_req.addr  = ns_addr;
					mem_req.wdata = cp_byte;
				end else begin
					mem_req.addr = os_addr;
				end
			end
			S_CP_WR: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = ns_addr;
				mem_req.wdata = mem_rdata;
			end
			S_HDR_NEW: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = ns_start_q[ADDR_W-1:0];
				mem_req.wdata = cfg.valid_mark;
			end
			S_HDR_OLD: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = cfg.invalid_mark;
			end
			S_SM_HDR: mem_req.addr = ADDR_W'(cfg.base_address);
			S_SM_CHK: begin
				mem_req.addr  = ADDR_W'(cfg.base_address);
				mem_req.we    = mem_rdata == cfg.invalid_mark;
				mem_req.wdata = cfg.valid_mark;
			end
			S_SM_FIELD: begin
				mem_req.we    = sm_in_rec;
				mem_req.addr  = sm_addr;
				mem_req.wdata = sm_byte;
			end
			S_SC_CHK: mem_req.addr = scan_start_q[ADDR_W-1:0];
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/eeprom_record_wear_leveler.sv
// Top level of the eeprom record wear leveler. A 1024-byte store holds one record in rotating
// slots of one header byte plus record_length payload bytes; all of it sits in one
// single-port synchronous ram, so every byte touched takes a port access of its own and the
// command sequencer walks them one at a time. After reset the store is swept to 0xFF, one
// byte per cycle; no item is taken during that sweep (configuration writes are). In a
// rotating write each copied byte is a read then a write and each new field byte a single
// write; a recover inspects headers in turn until one carries the valid mark, and an unused
// command, or a read or write of an unused size, ends without touching the store. The next
// item is taken while a result still waits at the output register. Configuration must be
// written only while the block is idle; the block itself does not enforce it.
module eeprom_record_wear_leveler import erwl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	erwl_in_if.sink     item,
	erwl_out_if.source  result,
	erwl_cfg_if.sink    cfg
);

	cfg_t              cfg_regs;
	item_t             in_item;
	res_t              out_res;
	mem_req_t          mem_req;
	logic [BYTE_W-1:0] mem_rdata;
	logic              in_ready;
	logic              out_valid;

	// item and result beats
	assign in_item.command       = item.command;
	assign in_item.field_size    = item.field_size;
	assign in_item.record_offset = item.record_offset;
	assign in_item.write_value   = item.write_value;
	assign item.ready            = in_ready;

	assign result.valid        = out_valid;
	assign result.read_value   = out_res.read_value;
	assign result.slot_number  = out_res.slot_number;
	assign result.slot_address = out_res.slot_address;

	// configuration registers
	erwl_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg),
		.regs   (cfg_regs)
	);

	// command sequencer
	erwl_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_regs),
		.in_valid  (item.valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.out_res   (out_res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// byte store
	erwl_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

`ifndef NO_ASSERTIONS
	// the store is never written while an item can be taken
	a_no_write_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !mem_req.we)
		else $error("store write while accepting items");

	// one item at a time: ready drops after an accepted beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("second item taken while busy");

	// a result appears only after the sequencer has been busy
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(!item.ready))
		else $error("result raised without a command in flight");
`endif

endmodule

>>> verif/erwl_checker.sv
// checker for the eeprom record wear leveler: predicts every result and compares it
module erwl_checker import erwl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	erwl_in_if   item,
	erwl_out_if  result,
	erwl_cfg_if  cfg,
	output int   fail_count,
	output int   pending,
	output int   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOT_COUNT = 1 << SLOT_W;
	localparam int unsigned SLOT_MASK  = SLOT_COUNT - 1;

	// shadow of the registers, the store and the live slot
	cfg_t              regs;
	logic [BYTE_W-1:0] mem [STORE_BYTES];
	logic [SLOT_W-1:0] live;

	// results predicted but not yet seen, oldest first
	res_t              due_results [$];
	res_t              want;
	item_t             beat_in;

	function automatic int unsigned slot_base(int unsigned k);
		return regs.base_address + k * (regs.record_length + HEADER_BYTES);
	endfunction

	function automatic logic [BYTE_W-1:0] peek(int unsigned addr);
		return mem[addr % STORE_BYTES];
	endfunction

	function automatic void poke(int unsigned addr, logic [BYTE_W-1:0] b);
		mem[addr % STORE_BYTES] = b;
	endfunction

	// apply one command to the shadow store and return the result it reports
	function automatic res_t run_command(item_t it);
		int unsigned nb, off, start, old_slot, nxt, old_pay, new_pay, found, sn, i, k;
		logic [VAL_W-1:0] rd;
		res_t r;
		case (it.field_size)
			SIZE_ONE:  nb = 1;
			SIZE_TWO:  nb = 2;
			SIZE_FOUR: nb = 4;
			default:   nb = 0;
		endcase
		off = it.record_offset;
		rd = '0;
		if (it.command == CMD_READ) begin
			// reads are not bounded by the record length
			start = regs.rotate_mode ? slot_base(live) : regs.base_address;
			for (i = 0; i < nb; i++)
				rd[8*i +: 8] = peek(start + HEADER_BYTES + off + i);
		end else if (it.command == CMD_WRITE && nb != 0) begin
			if (regs.rotate_mode) begin
				// copy into the next slot, merging the new field
				old_slot = live;
				nxt = (slot_base(old_slot + 1) > regs.end_limit) ? 0 : ((old_slot + 1) & SLOT_MASK);
				old_pay = slot_base(old_slot) + HEADER_BYTES;
				new_pay = slot_base(nxt) + HEADER_BYTES;
				for (i = 0; i < regs.record_length; i++) begin
					if (i >= off && i - off < nb)
						poke(new_pay + i, 8'(it.write_value >> (8 * (i - off))));
					else
						poke(new_pay + i, peek(old_pay + i));
				end
				poke(slot_base(nxt), regs.valid_mark);
				poke(slot_base(old_slot), regs.invalid_mark);
				live = SLOT_W'(nxt);
			end else begin
				// fixed slot: revive a retired header, then write in place
				if (peek(regs.base_address) == regs.invalid_mark)
					poke(regs.base_address, regs.valid_mark);
				for (i = 0; i < nb; i++) begin
					if (off + i < regs.record_length)
						poke(regs.base_address + HEADER_BYTES + off + i,
							8'(it.write_value >> (8 * i)));
				end
			end
		end else if (it.command == CMD_RECOVER) begin
			// first slot whose header carries the valid mark
			found = 0;
			for (k = 0; k < SLOT_COUNT && slot_base(k) < regs.end_limit; k++) begin
				if (peek(slot_base(k)) == regs.valid_mark) begin
					found = k;
					break;
				end
			end
			live = SLOT_W'(found);
		end
		sn = regs.rotate_mode ? live : 0;
		r.read_value   = rd;
		r.slot_number  = SLOT_W'(sn);
		r.slot_address = SADDR_W'(slot_base(sn));
		return r;
	endfunction

	task automatic check_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] got);
		if (got !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got);
			fail_count++;
		end
	endtask

	// watch the three channels on every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{RST_BASE, RST_END_LIMIT, RST_REC_LEN, RST_ROTATE, RST_VALID, RST_INVALID};
			foreach (mem[a]) mem[a] = ERASED;
			live = '0;
			due_results.delete();
			pending = 0;
		end else begin
			// register write beat
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_BASE:      regs.base_address  = cfg.data[BASE_W-1:0];
					REG_END_LIMIT: regs.end_limit     = cfg.data[END_W-1:0];
					REG_REC_LEN:   regs.record_length = cfg.data[LEN_W-1:0];
					REG_ROTATE:    regs.rotate_mode   = cfg.data[0];
					REG_VALID:     regs.valid_mark    = cfg.data[MARK_W-1:0];
					REG_INVALID:   regs.invalid_mark  = cfg.data[MARK_W-1:0];
					default: ;
				endcase
			end
			// result beat against the oldest prediction
			if (result.valid && result.ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0h slot %0d addr %0d",
						$time, result.read_value, result.slot_number, result.slot_address);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					checked++;
					check_field("read_value", want.read_value, result.read_value);
					check_field("slot_number", VAL_W'(want.slot_number), VAL_W'(result.slot_number));
					check_field("slot_address", VAL_W'(want.slot_address),
						VAL_W'(result.slot_address));
				end
			end
			// item beat: predict what it returns
			if (item.valid && item.ready) begin
				beat_in = '{item.command, item.field_size, item.record_offset, item.write_value};
				due_results.push_back(run_command(beat_in));
			end
			pending = due_results.size();
		end
	end

endmodule

>>> verif/eeprom_record_wear_leveler_tb.sv
// testbench top for the eeprom record wear leveler: clock, reset, stimulus and verdict
module eeprom_record_wear_leveler_tb import erwl_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// codes the block treats as no-ops (the unused size only in reads and writes)
	localparam logic [CMD_W-1:0]  CMD_NONE  = 2'd3;
	localparam logic [SIZE_W-1:0] SIZE_NONE = 2'd3;

	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n;

	erwl_in_if  item_ch ();
	erwl_out_if result_ch ();
	erwl_cfg_if cfg_ch ();

	int fail_count, pending, checked;
	int quiet_cycles;
	int hold_asks, hold_seen, hold_left;
	bit steady;
	cfg_t cur = '{RST_BASE, RST_END_LIMIT, RST_REC_LEN, RST_ROTATE, RST_VALID, RST_INVALID};
	int n_items, n_writes, n_reads, n_recovers, n_settings;

	eeprom_record_wear_leveler u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	erwl_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always #5ns clk = ~clk;

	// reset once at the start
	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// result side: random stalls, steady stretches and one long hold-off
	initial result_ch.ready = 1'b0;
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_asks) begin
			result_ch.ready <= 1'b0;
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
		end else begin
			result_ch.ready <= steady || ($urandom_range(99) >= 22);
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout, no beat for %0d cycles", $time, QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic item_t mk(logic [CMD_W-1:0] cmd, logic [SIZE_W-1:0] size,
		logic [OFF_W-1:0] off, logic [VAL_W-1:0] val);
		return '{cmd, size, off, val};
	endfunction

	// mostly reads and writes inside the record, some recovers and stray codes
	function automatic item_t random_item();
		item_t it;
		int unsigned pick;
		pick = $urandom_range(99);
		it.command = (pick < 45) ? CMD_WRITE : (pick < 82) ? CMD_READ :
			(pick < 95) ? CMD_RECOVER : CMD_NONE;
		case ($urandom_range(9))
			0:       it.field_size = SIZE_NONE;
			1, 2, 3: it.field_size = SIZE_ONE;
			4, 5, 6: it.field_size = SIZE_TWO;
			default: it.field_size = SIZE_FOUR;
		endcase
		it.record_offset = ($urandom_range(9) < 7) ? OFF_W'($urandom_range(cur.record_length)) :
			OFF_W'($urandom_range(1023));
		case ($urandom_range(9))
			0:       it.write_value = '0;
			1:       it.write_value = '1;
			default: it.write_value = $urandom();
		endcase
		return it;
	endfunction

	function automatic cfg_t random_settings();
		cfg_t c;
		c.base_address = BASE_W'($urandom_range(1023));
		case ($urandom_range(3))
			0:       c.end_limit = 11'd1024;
			1:       c.end_limit = 11'd2047;
			2:       c.end_limit = END_W'($urandom_range(2047));
			default: c.end_limit = END_W'($urandom_range(200));
		endcase
		c.record_length = ($urandom_range(9) == 0) ? '0 : LEN_W'($urandom_range(1, 40));
		c.rotate_mode = ($urandom_range(9) < 7);
		if ($urandom_range(3) == 0) begin
			c.valid_mark   = 8'h00;
			c.invalid_mark = 8'hFF;
		end else begin
			c.valid_mark   = MARK_W'($urandom());
			c.invalid_mark = MARK_W'($urandom());
		end
		return c;
	endfunction

	// one item beat, with random gaps unless the sender runs steady
	task automatic push_item(item_t it);
		while (!steady && $urandom_range(99) < 22) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.command       <= it.command;
		item_ch.field_size    <= it.field_size;
		item_ch.record_offset <= it.record_offset;
		item_ch.write_value   <= it.write_value;
		do @(posedge clk); while (!item_ch.ready);
		n_items++;
		case (it.command)
			CMD_WRITE:   n_writes++;
			CMD_READ:    n_reads++;
			CMD_RECOVER: n_recovers++;
			default: ;
		endcase
	endtask

	task automatic random_items(int n);
		repeat (n) push_item(random_item());
	endtask

	// stop offering and wait until every result is back
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// write every register, block idle
	task automatic load_settings(cfg_t c);
		write_reg(REG_BASE, CFG_DATA_W'(c.base_address));
		write_reg(REG_END_LIMIT, CFG_DATA_W'(c.end_limit));
		write_reg(REG_REC_LEN, CFG_DATA_W'(c.record_length));
		write_reg(REG_ROTATE, CFG_DATA_W'(c.rotate_mode));
		write_reg(REG_VALID, CFG_DATA_W'(c.valid_mark));
		write_reg(REG_INVALID, CFG_DATA_W'(c.invalid_mark));
		cfg_ch.valid <= 1'b0;
		cur = c;
		n_settings++;
	endtask

	initial begin
		item_ch.valid         = 1'b0;
		item_ch.command       = CMD_READ;
		item_ch.field_size    = SIZE_ONE;
		item_ch.record_offset = '0;
		item_ch.write_value   = '0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = REG_BASE;
		cfg_ch.data           = '0;
		steady                = 1'b0;
		n_settings            = 1;
		wait (arst_n === 1'b1);

		// reset settings: erased reads, address wrap, fields past the record end, no-ops
		push_item(mk(CMD_READ, SIZE_ONE, 10'd0, 32'h0));
		push_item(mk(CMD_READ, SIZE_FOUR, 10'd1023, 32'hFFFF_FFFF));
		push_item(mk(CMD_READ, SIZE_NONE, 10'd5, 32'h0));
		push_item(mk(CMD_WRITE, SIZE_FOUR, 10'd0, 32'h1234_5678));
		push_item(mk(CMD_WRITE, SIZE_TWO, 10'd15, 32'h0000_ABCD));
		push_item(mk(CMD_WRITE, SIZE_FOUR, 10'd14, 32'hDEAD_BEEF));
		push_item(mk(CMD_WRITE, SIZE_ONE, 10'd1023, 32'h0000_005A));
		push_item(mk(CMD_WRITE, SIZE_NONE, 10'd0, 32'hFFFF_FFFF));
		push_item(mk(CMD_NONE, SIZE_FOUR, 10'd1023, 32'hFFFF_FFFF));
		push_item(mk(CMD_WRITE, SIZE_FOUR, 10'd4, 32'hFFFF_FFFF));
		push_item(mk(CMD_WRITE, SIZE_ONE, 10'd8, 32'h0));
		push_item(mk(CMD_READ, SIZE_FOUR, 10'd0, 32'h0));
		push_item(mk(CMD_READ, SIZE_TWO, 10'd14, 32'h0));
		push_item(mk(CMD_READ, SIZE_FOUR, 10'd15, 32'h0));
		push_item(mk(CMD_RECOVER, SIZE_ONE, 10'd0, 32'h0));
		push_item(mk(CMD_READ, SIZE_FOUR, 10'd4, 32'h0));
		random_items(80);

		// one slot only: the second write rewrites the live slot in place
		settle();
		load_settings(cfg_t'{10'd0, 11'd4, 10'd4, 1'b1, 8'hA5, 8'h5A});
		push_item(mk(CMD_WRITE, SIZE_TWO, 10'd0, 32'h0000_C3C3));
		push_item(mk(CMD_WRITE, SIZE_FOUR, 10'd1, 32'h8765_4321));
		push_item(mk(CMD_READ, SIZE_FOUR, 10'd0, 32'h0));
		push_item(mk(CMD_RECOVER, SIZE_ONE, 10'd0, 32'h0));
		random_items(40);

		// zero record length, recover scan bounded by the slot count
		settle();
		load_settings(cfg_t'{10'd1000, 11'd2047, 10'd0, 1'b1, 8'h00, 8'hFF});
		push_item(mk(CMD_WRITE, SIZE_TWO, 10'd0, 32'h0000_1111));
		push_item(mk(CMD_READ, SIZE_TWO, 10'd0, 32'h0));
		push_item(mk(CMD_RECOVER, SIZE_ONE, 10'd0, 32'h0));
		random_items(40);

		// fixed slot with a retired header
		settle();
		load_settings(cfg_t'{10'd100, 11'd1024, 10'd8, 1'b0, 8'h3C, 8'hFF});
		push_item(mk(CMD_WRITE, SIZE_TWO, 10'd7, 32'h0000_BEEF));
		push_item(mk(CMD_READ, SIZE_TWO, 10'd7, 32'h0));
		push_item(mk(CMD_WRITE, SIZE_ONE, 10'd0, 32'h0000_0042));
		random_items(60);

		// largest record and wrap limit, few items since each write copies it all
		settle();
		load_settings(cfg_t'{10'd0, 11'd2047, 10'd1023, 1'b1, 8'h00, 8'hFF});
		random_items(8);

		// zero wrap limit, both marks equal
		settle();
		load_settings(cfg_t'{10'd512, 11'd0, 10'd20, 1'b1, 8'h77, 8'h77});
		random_items(40);

		// no idling on either side, then a long result hold-off to back up the input
		settle();
		load_settings(cfg_t'{10'd1023, 11'd1024, 10'd12, 1'b1, 8'h00, 8'hFF});
		steady = 1'b1;
		hold_asks++;
		random_items(80);
		settle();
		steady = 1'b0;

		// random settings
		repeat (8) begin
			settle();
			load_settings(random_settings());
			random_items(80);
		end

		settle();
		repeat (50) @(posedge clk);
		$display("run covered %0d items (%0d writes, %0d reads, %0d recovers) over %0d settings",
			n_items, n_writes, n_reads, n_recovers, n_settings);
		$display("%0d results compared, %0d mismatches, %0d left waiting",
			checked, fail_count, pending);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/erwl_pkg.sv
rtl/erwl_if.sv
rtl/erwl_ram.sv
rtl/erwl_cfg.sv
rtl/erwl_seq.sv
rtl/eeprom_record_wear_leveler.sv
verif/erwl_checker.sv
verif/eeprom_record_wear_leveler_tb.sv
